// ===== rtl/gain_phase_margin_finder_assert.svh =====
// Assertion macros shared by the margin finder modules.
`ifndef GAIN_PHASE_MARGIN_FINDER_ASSERT_SVH
`define GAIN_PHASE_MARGIN_FINDER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define GPM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/gpm_pkg.sv =====
// Shared types and constants of the gain and phase margin finder.
package gpm_pkg;

   // 180 degrees in Q16.8
   localparam logic signed [24:0] PH_OFFSET = 25'sd46080;

   // Serial divider geometry: quotient bits, dividend, divisor and remainder widths
   localparam int QBITS  = 25;
   localparam int DIV_NW = 52;
   localparam int DIV_DW = 26;
   localparam int DIV_RW = DIV_DW + 1;
   localparam int CNT_W  = $clog2(QBITS);

   localparam int REQ_W = 64;
   localparam int RSP_W = 88;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_EVAL   = 8'b0000_0010,
      ST_JOB    = 8'b0000_0100,
      ST_MUL    = 8'b0000_1000,
      ST_START  = 8'b0001_0000,
      ST_DIV    = 8'b0010_0000,
      ST_WRITE  = 8'b0100_0000,
      ST_COMMIT = 8'b1000_0000
   } state_type;

   // Interpolation jobs, run in this order
   typedef enum logic [1:0] {
      JOB_GC_FREQ = 2'd0,
      JOB_PM      = 2'd1,
      JOB_PC_FREQ = 2'd2,
      JOB_GM      = 2'd3
   } job_type;

   typedef struct packed {
      logic    load;
      logic    eval;
      logic    mul;
      logic    start;
      logic    write;
      logic    commit;
      job_type job;
   } cmd_type;

   typedef struct packed {
      logic do_pm;
      logic do_gm;
      logic div_done;
      logic last;
      logic out_busy;
   } sts_type;

endpackage

// ===== rtl/gpm_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module gpm_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [gpm_pkg::DIV_NW-1:0]      n,
   input  logic [gpm_pkg::DIV_DW-1:0]      d,
   output logic                            done,
   output logic [gpm_pkg::QBITS-1:0]       q
);

   logic                           busy_ff, busy_in;
   logic [gpm_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic [gpm_pkg::DIV_RW-1:0]     rem_ff, rem_in;
   logic [gpm_pkg::QBITS-1:0]      quo_ff, quo_in;
   logic [gpm_pkg::DIV_DW-1:0]     d_ff, d_in;
   logic [gpm_pkg::DIV_RW-1:0]     trial;
   logic                           fits;

   assign trial = {rem_ff[gpm_pkg::DIV_RW-2:0], quo_ff[gpm_pkg::QBITS-1]};
   assign fits  = trial >= {1'b0, d_ff};
   assign done  = busy_ff && (cnt_ff == gpm_pkg::CNT_W'(gpm_pkg::QBITS - 1));
   assign q     = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      d_in    = d_ff;
      if (start) begin
         // quotient fits QBITS, so the upper dividend bits stay below the divisor
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = n[gpm_pkg::DIV_NW-1:gpm_pkg::QBITS];
         quo_in  = n[gpm_pkg::QBITS-1:0];
         d_in    = d;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (done) begin
            busy_in = 1'b0;
         end
         if (fits) begin
            rem_in = trial - {1'b0, d_ff};
            quo_in = {quo_ff[gpm_pkg::QBITS-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[gpm_pkg::QBITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      d_ff   <= d_in;
   end

endmodule

// ===== rtl/gpm_datapath.sv =====
// Sample registers, crossing detection, interpolation and result register.
`include "gain_phase_margin_finder_assert.svh"

module gpm_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  gpm_pkg::cmd_type            cmd,
   output gpm_pkg::sts_type            sts,
   input  logic [gpm_pkg::REQ_W-1:0]   req_tdata,
   input  logic                        req_tlast,
   input  logic                        rsp_tready,
   output logic                        rsp_tvalid,
   output logic [gpm_pkg::RSP_W-1:0]   rsp_tdata
);

   logic signed [15:0] cur_freq_ff, prev_freq_ff, gc_freq_ff, pc_freq_ff;
   logic signed [23:0] cur_mag_ff, prev_mag_ff, cur_phase_ff, prev_phase_ff;
   logic signed [23:0] pm_value_ff, gm_value_ff;
   logic               cur_last_ff, have_prev_ff, pm_found_ff, gm_found_ff;
   logic               do_pm_ff, do_gm_ff;
   logic signed [50:0] num_ff;
   logic signed [25:0] den_ff;
   logic               zero_ff, neg_ff;
   logic               rsp_valid_ff;
   logic [gpm_pkg::RSP_W-1:0] rsp_data_ff;

   logic signed [24:0] mag_a, mag_b, ph_a, ph_b, a_sel, b_sel;
   logic signed [23:0] v0_sel, v1_sel;
   logic signed [25:0] a_neg;
   logic signed [24:0] v_diff;
   logic signed [50:0] prod;
   logic [50:0]        num_mag;
   logic [25:0]        den_mag;
   logic [gpm_pkg::DIV_NW-1:0] div_n;
   logic [gpm_pkg::DIV_DW-1:0] div_d;
   logic               div_done;
   logic [gpm_pkg::QBITS-1:0] div_q, q_eff;
   logic signed [25:0] v0_x, q_x, interp, pm_sum, gm_neg;
   logic               pm_stable, gm_ok;
   logic [gpm_pkg::RSP_W-1:0] rsp_word;

   function automatic logic crosses(input logic signed [24:0] a,
                                    input logic signed [24:0] b);
      return (a == 25'sd0) || (a[24] != b[24]);
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
      logic signed [23:0] r;
      if (v > 26'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -26'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

   assign mag_a = {prev_mag_ff[23], prev_mag_ff};
   assign mag_b = {cur_mag_ff[23], cur_mag_ff};
   assign ph_a  = $signed({prev_phase_ff[23], prev_phase_ff}) + gpm_pkg::PH_OFFSET;
   assign ph_b  = $signed({cur_phase_ff[23], cur_phase_ff}) + gpm_pkg::PH_OFFSET;

   always_comb begin
      case (cmd.job) inside
         gpm_pkg::JOB_GC_FREQ, gpm_pkg::JOB_PM: begin
            a_sel = mag_a;
            b_sel = mag_b;
         end
         default: begin
            a_sel = ph_a;
            b_sel = ph_b;
         end
      endcase
      case (cmd.job) inside
         gpm_pkg::JOB_GC_FREQ, gpm_pkg::JOB_PC_FREQ: begin
            v0_sel = {{8{prev_freq_ff[15]}}, prev_freq_ff};
            v1_sel = {{8{cur_freq_ff[15]}}, cur_freq_ff};
         end
         gpm_pkg::JOB_PM: begin
            v0_sel = prev_phase_ff;
            v1_sel = cur_phase_ff;
         end
         default: begin
            v0_sel = prev_mag_ff;
            v1_sel = cur_mag_ff;
         end
      endcase
   end

   // numerator (-a)*(v1-v0), denominator b-a
   assign a_neg  = 26'sd0 - $signed({a_sel[24], a_sel});
   assign v_diff = $signed({v1_sel[23], v1_sel}) - $signed({v0_sel[23], v0_sel});
   assign prod   = a_neg * v_diff;

   // round to nearest: (2|num| + |den|) / (2|den|)
   assign num_mag = num_ff[50] ? 51'(-num_ff) : 51'(num_ff);
   assign den_mag = den_ff[25] ? 26'(-den_ff) : 26'(den_ff);
   assign div_n   = {1'b0, num_mag[49:0], 1'b0} + {26'd0, den_mag};
   assign div_d   = {den_mag[24:0], 1'b0};

   gpm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.start),
      .n     (div_n),
      .d     (div_d),
      .done  (div_done),
      .q     (div_q)
   );

   assign q_eff  = zero_ff ? '0 : div_q;
   assign v0_x   = $signed({{2{v0_sel[23]}}, v0_sel});
   assign q_x    = $signed({1'b0, q_eff});
   assign interp = neg_ff ? v0_x - q_x : v0_x + q_x;
   assign pm_sum = interp + 26'sd46080;
   assign gm_neg = 26'sd0 - interp;

   assign pm_stable = pm_found_ff && (pm_value_ff > 24'sd0);
   assign gm_ok     = !gm_found_ff || (gm_value_ff > 24'sd0);

   // fields from lowest bit: enough, has_pm, pm, gc_freq, has_gm, gm, pc_freq, stable
   assign rsp_word = {4'd0, pm_stable && gm_ok,
                      gm_found_ff ? pc_freq_ff : 16'd0,
                      gm_found_ff ? gm_value_ff : 24'd0,
                      gm_found_ff,
                      pm_found_ff ? gc_freq_ff : 16'd0,
                      pm_found_ff ? pm_value_ff : 24'd0,
                      pm_found_ff, 1'b1};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_freq_ff  <= req_tdata[15:0];
         cur_mag_ff   <= req_tdata[39:16];
         cur_phase_ff <= req_tdata[63:40];
         cur_last_ff  <= req_tlast;
      end
      if (cmd.mul) begin
         num_ff  <= prod;
         den_ff  <= $signed({b_sel[24], b_sel}) - $signed({a_sel[24], a_sel});
         zero_ff <= (a_sel == 25'sd0);
      end
      if (cmd.start) begin
         neg_ff <= num_ff[50] ^ den_ff[25];
      end
      if (cmd.write) begin
         case (cmd.job)
            gpm_pkg::JOB_GC_FREQ: gc_freq_ff  <= interp[15:0];
            gpm_pkg::JOB_PM:      pm_value_ff <= sat24(pm_sum);
            gpm_pkg::JOB_PC_FREQ: pc_freq_ff  <= interp[15:0];
            default:              gm_value_ff <= sat24(gm_neg);
         endcase
      end
      if (cmd.commit) begin
         prev_freq_ff  <= cur_freq_ff;
         prev_mag_ff   <= cur_mag_ff;
         prev_phase_ff <= cur_phase_ff;
         if (cur_last_ff) begin
            // a one-sample sweep reports all zero
            rsp_data_ff <= have_prev_ff ? rsp_word : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         pm_found_ff  <= 1'b0;
         gm_found_ff  <= 1'b0;
         do_pm_ff     <= 1'b0;
         do_gm_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.eval) begin
            do_pm_ff <= have_prev_ff && !pm_found_ff && crosses(mag_a, mag_b);
            do_gm_ff <= have_prev_ff && !gm_found_ff && crosses(ph_a, ph_b);
         end
         if (cmd.write && cmd.job == gpm_pkg::JOB_PM) begin
            pm_found_ff <= 1'b1;
         end
         if (cmd.write && cmd.job == gpm_pkg::JOB_GM) begin
            gm_found_ff <= 1'b1;
         end
         if (cmd.commit) begin
            if (cur_last_ff) begin
               // end of sweep: start over
               have_prev_ff <= 1'b0;
               pm_found_ff  <= 1'b0;
               gm_found_ff  <= 1'b0;
            end else begin
               have_prev_ff <= 1'b1;
            end
         end
         if (cmd.commit && cur_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign sts.do_pm    = do_pm_ff;
   assign sts.do_gm    = do_gm_ff;
   assign sts.div_done = div_done;
   assign sts.last     = cur_last_ff;
   assign sts.out_busy = rsp_valid_ff && !rsp_tready;

   `GPM_ASSERT_NEXT(a_sweep_clear, clock, reset, cmd.commit && cur_last_ff,
      !have_prev_ff && !pm_found_ff && !gm_found_ff,
      "sweep state not cleared after last word")
   `GPM_ASSERT_NEXT(a_rsp_load, clock, reset, cmd.commit && cur_last_ff,
      rsp_valid_ff, "result not raised after last word")
   `GPM_ASSERT_NEXT(a_pm_found, clock, reset, cmd.write && cmd.job == gpm_pkg::JOB_PM,
      pm_found_ff, "phase margin write did not mark found")

endmodule

// ===== rtl/gpm_ctrl.sv =====
// Sequencer that steps each sample through crossing checks and interpolations.
`include "gain_phase_margin_finder_assert.svh"

module gpm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output gpm_pkg::cmd_type  cmd,
   input  gpm_pkg::sts_type  sts
);

   gpm_pkg::state_type state_ff, state_in;
   gpm_pkg::job_type   job_ff, job_in;
   logic               job_en;

   always_comb begin
      case (job_ff) inside
         gpm_pkg::JOB_GC_FREQ, gpm_pkg::JOB_PM: job_en = sts.do_pm;
         default:                               job_en = sts.do_gm;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      cmd        = '0;
      cmd.job    = job_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         gpm_pkg::ST_IDLE: begin
            // hold off the input while in reset
            req_tready = !reset;
            if (req_tvalid && req_tready) begin
               cmd.load = 1'b1;
               state_in = gpm_pkg::ST_EVAL;
            end
         end
         gpm_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            job_in   = gpm_pkg::JOB_GC_FREQ;
            state_in = gpm_pkg::ST_JOB;
         end
         gpm_pkg::ST_JOB: begin
            if (job_en) begin
               state_in = gpm_pkg::ST_MUL;
            end else if (job_ff == gpm_pkg::JOB_GM) begin
               state_in = gpm_pkg::ST_COMMIT;
            end else begin
               job_in = gpm_pkg::job_type'(job_ff + 2'd1);
            end
         end
         gpm_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = gpm_pkg::ST_START;
         end
         gpm_pkg::ST_START: begin
            cmd.start = 1'b1;
            state_in  = gpm_pkg::ST_DIV;
         end
         gpm_pkg::ST_DIV: begin
            if (sts.div_done) begin
               state_in = gpm_pkg::ST_WRITE;
            end
         end
         gpm_pkg::ST_WRITE: begin
            cmd.write = 1'b1;
            if (job_ff == gpm_pkg::JOB_GM) begin
               state_in = gpm_pkg::ST_COMMIT;
            end else begin
               job_in   = gpm_pkg::job_type'(job_ff + 2'd1);
               state_in = gpm_pkg::ST_JOB;
            end
         end
         gpm_pkg::ST_COMMIT: begin
            // hold a last sample while the previous result still waits
            if (!(sts.last && sts.out_busy)) begin
               cmd.commit = 1'b1;
               state_in   = gpm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gpm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gpm_pkg::ST_IDLE;
         job_ff   <= gpm_pkg::JOB_GC_FREQ;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
      end
   end

   `GPM_ASSERT_NEXT(a_accept_eval, clock, reset, req_tvalid && req_tready,
      state_ff == gpm_pkg::ST_EVAL, "accepted word not evaluated")
   `GPM_ASSERT_NEXT(a_div_wait, clock, reset, state_ff == gpm_pkg::ST_DIV && !sts.div_done,
      state_ff == gpm_pkg::ST_DIV, "left divide before done")
   `GPM_ASSERT_SAME(a_no_commit_busy, clock, reset, cmd.commit && sts.last,
      !sts.out_busy, "result overwritten while waiting")

endmodule

// ===== rtl/gain_phase_margin_finder.sv =====
// Top level of the gain and phase margin finder.
//
//   Channel  Dir  Signals                        Content
//   req      in   req_tvalid/tready/tdata/tlast  one sweep sample, tlast ends sweep
//   rsp      out  rsp_tvalid/tready/tdata        margins and verdict, one per sweep
//
// Each sample is evaluated for crossings, then runs up to four interpolations,
// each through the shared 25-step serial divider, then commits; no new sample
// is accepted until the previous one has committed. Reset clears the sweep
// flags and drops any waiting result.
// A result waiting on rsp_tready stalls only the next last sample, at commit.
module gain_phase_margin_finder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // log_freq[15:0], mag_db[39:16], phase_deg[63:40]
   input  logic [gpm_pkg::REQ_W-1:0]   req_tdata,
   input  logic                        req_tlast,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // enough_points[0], has_phase_margin[1], phase_margin[25:2],
   // gain_cross_freq[41:26], has_gain_margin[42], gain_margin[66:43],
   // phase_cross_freq[82:67], stable[83], zero[87:84]
   output logic [gpm_pkg::RSP_W-1:0]   rsp_tdata
);

   gpm_pkg::cmd_type cmd;
   gpm_pkg::sts_type sts;

   gpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   gpm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== tb/sv/tb_gain_phase_margin_finder.sv =====
// Self-checking testbench for the gain and phase margin finder, driven over its stream ports.
module tb_gain_phase_margin_finder;

   localparam int     RSP_W        = gpm_pkg::RSP_W;
   localparam int     REQ_W        = gpm_pkg::REQ_W;
   localparam longint HALF_TURN    = gpm_pkg::PH_OFFSET;
   localparam longint S24_MAX      = 64'sd8388607;
   localparam longint S24_MIN      = -64'sd8388608;
   localparam int     DRAIN_CYCLES = 150;
   localparam int     LIMIT_CYCLES = 1_000_000;
   localparam int     ITEMS_PER_PHASE = 600;

   // Result word layout, lowest field last
   typedef struct packed {
      logic [3:0]  pad;
      logic        stable;
      logic [15:0] phase_cross_freq;
      logic [23:0] gain_margin;
      logic        has_gain_margin;
      logic [15:0] gain_cross_freq;
      logic [23:0] phase_margin;
      logic        has_phase_margin;
      logic        enough_points;
   } margin_rpt_type;

   class margin_scoreboard;
      margin_rpt_type pending_reports[$];
      int          errors;
      longint      prev_f, prev_m, prev_p;
      bit          have_prev, pm_found, gm_found;
      longint      pm_val, gc_f, gm_val, pc_f;

      function new();
         errors = 0;
         clear_sweep();
      endfunction

      function void clear_sweep();
         prev_f = 0;
         prev_m = 0;
         prev_p = 0;
         have_prev = 0;
         pm_found = 0;
         pm_val = 0;
         gc_f = 0;
         gm_found = 0;
         gm_val = 0;
         pc_f = 0;
      endfunction

      function int pending();
         return pending_reports.size();
      endfunction

      task report_mismatch(string what);
         $display("ERROR @%0t: %s", $realtime, what);
         errors++;
      endtask

      function longint sat24(longint v);
         if (v > S24_MAX) return S24_MAX;
         if (v < S24_MIN) return S24_MIN;
         return v;
      endfunction

      function bit crosses(longint a, longint b);
         return (a == 0) || ((a < 0) != (b < 0));
      endfunction

      // Linear interpolation, quotient rounded to nearest with ties away from zero
      function longint lerp(longint a, longint b, longint v0, longint v1);
         longint num, den, un, ud, q;
         bit neg;
         if (a == 0 || b == a) return v0;
         num = -a * (v1 - v0);
         den = b - a;
         neg = (num < 0) != (den < 0);
         un = (num < 0) ? -num : num;
         ud = (den < 0) ? -den : den;
         q = (un * 2 + ud) / (ud * 2);
         return neg ? v0 - q : v0 + q;
      endfunction

      function void note_sample(logic [15:0] f16, logic [23:0] m24, logic [23:0] p24,
                                bit last);
         longint f, m, p, a, b;
         bit enough;
         margin_rpt_type r;
         f = longint'($signed(f16));
         m = longint'($signed(m24));
         p = longint'($signed(p24));
         enough = have_prev;
         if (have_prev) begin
            if (!pm_found && crosses(prev_m, m)) begin
               gc_f = lerp(prev_m, m, prev_f, f);
               pm_val = sat24(HALF_TURN + lerp(prev_m, m, prev_p, p));
               pm_found = 1;
            end
            if (!gm_found) begin
               a = prev_p + HALF_TURN;
               b = p + HALF_TURN;
               if (crosses(a, b)) begin
                  pc_f = lerp(a, b, prev_f, f);
                  gm_val = sat24(-lerp(a, b, prev_m, m));
                  gm_found = 1;
               end
            end
         end
         prev_f = f;
         prev_m = m;
         prev_p = p;
         have_prev = 1;
         if (!last) return;
         r = '0;
         if (enough) begin
            r.enough_points    = 1'b1;
            r.has_phase_margin = pm_found;
            r.phase_margin     = pm_found ? pm_val[23:0] : '0;
            r.gain_cross_freq  = pm_found ? gc_f[15:0] : '0;
            r.has_gain_margin  = gm_found;
            r.gain_margin      = gm_found ? gm_val[23:0] : '0;
            r.phase_cross_freq = gm_found ? pc_f[15:0] : '0;
            r.stable = pm_found && pm_val > 0 && (!gm_found || gm_val > 0);
         end
         pending_reports.push_back(r);
         clear_sweep();
      endfunction

      task cmp_field(string name, longint got, longint want);
         if (got != want)
            report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
      endtask

      task check_report(logic [RSP_W-1:0] data);
         margin_rpt_type got, want;
         got = data;
         if (pending_reports.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: %h", data));
            return;
         end
         want = pending_reports.pop_front();
         cmp_field("enough_points", got.enough_points, want.enough_points);
         cmp_field("has_phase_margin", got.has_phase_margin, want.has_phase_margin);
         cmp_field("phase_margin", $signed(got.phase_margin), $signed(want.phase_margin));
         cmp_field("gain_cross_freq", $signed(got.gain_cross_freq),
                   $signed(want.gain_cross_freq));
         cmp_field("has_gain_margin", got.has_gain_margin, want.has_gain_margin);
         cmp_field("gain_margin", $signed(got.gain_margin), $signed(want.gain_margin));
         cmp_field("phase_cross_freq", $signed(got.phase_cross_freq),
                   $signed(want.phase_cross_freq));
         cmp_field("stable", got.stable, want.stable);
         cmp_field("pad", got.pad, want.pad);
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             req_tlast = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   margin_scoreboard sb = new();
   int tx_idle_pct = 16;
   int rx_idle_pct = 57;
   int items_sent = 0;
   int cycle_count = 0;

   gain_phase_margin_finder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("** gain_phase_margin_finder: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_report(rsp_tdata);
   end

   function automatic longint clamp(longint v, longint lo, longint hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // Hold the word until the block takes it, then log it for prediction
   task automatic send_sample(longint f, longint m, longint p, bit last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {p[23:0], m[23:0], f[15:0]};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_sample(f[15:0], m[23:0], p[23:0], last);
      items_sent++;
   endtask

   task automatic run_directed();
      // one-sample sweep: nothing to interpolate
      send_sample(32767, 8388607, 8388607, 1);
      // magnitude exactly 0 dB at the first sample, phase margin saturates
      send_sample(-32768, 0, 8388607, 0);
      send_sample(32767, -8388608, -8388608, 1);
      // phase exactly -180 at the first sample, gain margin saturates
      send_sample(100, -8388608, -46080, 0);
      send_sample(200, 8388607, 1000, 1);
      // no crossing of either kind
      send_sample(0, 100, 0, 0);
      send_sample(10, 200, 100, 0);
      send_sample(20, 300, 50, 1);
      // well-behaved stable loop
      send_sample(-8192, 5120, -23040, 0);
      send_sample(-4096, 2560, -30720, 0);
      send_sample(0, -256, -38400, 0);
      send_sample(4096, -2560, -48640, 0);
      send_sample(8192, -5120, -51200, 1);
      // half-way ties on both interpolations
      send_sample(0, -1, -46081, 0);
      send_sample(1, 1, -46079, 1);
      // negative phase margin, no phase crossing
      send_sample(0, 2560, -51200, 0);
      send_sample(4096, -2560, -56320, 1);
      // phase crossing while magnitude is still positive
      send_sample(0, 2560, -40000, 0);
      send_sample(4096, 1280, -50000, 0);
      send_sample(8192, -1280, -52000, 1);
   endtask

   // Sweep shaped like a real loop: rising frequency, falling gain and phase that may reverse
   task automatic run_shaped_sweep();
      int n;
      longint f, m, p, df, dm, dp, ms, ps;
      n  = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 12);
      f  = -32768 + longint'($urandom_range(40000));
      df = $urandom_range(1, 4000);
      m  = longint'($urandom_range(40000)) - 8000;
      dm = -longint'($urandom_range(1, 6000));
      p  = -longint'($urandom_range(40000));
      dp = -longint'($urandom_range(1, 12000));
      if ($urandom_range(9) == 0) dm = dm * 1000;
      if ($urandom_range(9) == 0) dp = dp * 1000;
      for (int i = 0; i < n; i++) begin
         ms = ($urandom_range(7) == 0) ? 0 : m;
         ps = ($urandom_range(7) == 0) ? -HALF_TURN : p;
         send_sample(clamp(f, -32768, 32767), clamp(ms, S24_MIN, S24_MAX),
                     clamp(ps, S24_MIN, S24_MAX), i == n - 1);
         f = f + df;
         m = m + dm;
         p = p + dp;
         if ($urandom_range(15) == 0) dm = -dm;
         if ($urandom_range(15) == 0) dp = -dp;
      end
   endtask

   // Raw random words with a random sweep end
   task automatic run_noise();
      int n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
         send_sample($urandom(), $urandom(), $urandom(), $urandom_range(3) == 0);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int target;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin tx_idle_pct = 16; rx_idle_pct = 57; end
            1: begin tx_idle_pct = 57; rx_idle_pct = 16; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         target = items_sent + ITEMS_PER_PHASE;
         while (items_sent < target) begin
            if ($urandom_range(9) < 7)
               run_shaped_sweep();
            else
               run_noise();
         end
         // stop sending until every result is back
         drain();
      end
      if (sb.errors == 0)
         $display("** gain_phase_margin_finder: PASSED **");
      else
         $display("** gain_phase_margin_finder: FAILED **");
      $finish;
   end

endmodule
